// ----- sv/spq_pkg.sv -----
// shared types, codes and constants of the sorted priority queue
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int ID_W         = 16;
    localparam int PRIO_W       = 8;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } slot_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_CAPTURE,
        CMD_INSERT,
        CMD_REMOVE
    } cell_cmd_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_cmd_t         cmd;
        logic              pop;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } cell_ctl_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

// ----- sv/sorted_priority_queue_core.sv -----
// top level of the sorted priority queue: controller, cell row and result register
//
// The queue keeps up to CAPACITY (id, priority) entries in a row of cells,
// head in cell 0, sorted by descending priority with equal priorities kept
// first-in-first-out. Each operation is a compare followed by a shift: when a
// beat is accepted every cell compares its entry against the request in
// parallel and registers the result; in the execute state, once the output
// register is free or emptying, the cells shift their entries one place
// toward or away from the head in a single step, and the result beat is
// loaded into the output register. No new beat is taken until it executes.
// While a finished result waits in the output register with m_axis_tready
// low, one further beat is still accepted and compared; its shift then waits,
// with the input blocked, until the held result leaves. Insert into a full
// queue returns status full and leaves the queue unchanged; pop and remove on
// an empty queue return status empty; remove with no matching id returns
// status not-found. Remove by id deletes the first matching entry in queue
// order. The removed entry's id and priority are returned, zero when nothing
// is removed.
module sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // task_id[15:0], priority_req[23:16], zero pad
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_id[15:0], out_priority[23:16], zero pad
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    import spq_pkg::*;

    // controller state
    state_t state_reg, state_next;

    // held request
    logic [MODE_W-1:0] mode_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PRIO_W-1:0] prio_reg;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ID_W-1:0]     m_id_reg;
    logic [PRIO_W-1:0]   m_prio_reg;

    // cell row
    cell_ctl_t           ctl;
    slot_t               slots [CAPACITY];
    logic [CAPACITY-1:0] ge_vec;
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] seen_vec;
    logic [CAPACITY-1:0] first_vec;
    logic [CAPACITY-1:0] valid_vec;

    logic s_accept;
    logic exec_fire;
    logic q_full;
    logic q_empty;
    logic q_found;

    // result of the operation under way
    logic [STATUS_W-1:0] res_status;
    logic [ID_W-1:0]     res_id;
    logic [PRIO_W-1:0]   res_prio;
    logic [ID_W-1:0]     sel_id;
    logic [PRIO_W-1:0]   sel_prio;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb begin
        s_axis_tready = 1'b0;
        exec_fire     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_EXEC: begin
                // the result register must be free or emptying this cycle
                exec_fire = !m_valid_reg || m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    assign s_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= s_axis_tuser;
            id_reg   <= s_axis_tdata[ID_W-1:0];
            prio_reg <= s_axis_tdata[ID_W+PRIO_W-1:ID_W];
        end
    end

    // queue status from the ends of the row
    assign q_full  = slots[CAPACITY-1].valid;
    assign q_empty = !slots[0].valid;
    assign q_found = seen_vec[CAPACITY-1];

    // broadcast to the cells: compare on accept, shift on execute
    always_comb begin
        ctl.cmd  = CMD_HOLD;
        ctl.pop  = (s_axis_tuser == MODE_POP);
        ctl.id   = id_reg;
        ctl.prio = prio_reg;
        if (s_accept) begin
            ctl.cmd  = CMD_CAPTURE;
            ctl.id   = s_axis_tdata[ID_W-1:0];
            ctl.prio = s_axis_tdata[ID_W+PRIO_W-1:ID_W];
        end else if (exec_fire) begin
            if (mode_reg == MODE_INSERT && !q_full) begin
                ctl.cmd = CMD_INSERT;
            end else if (mode_reg == MODE_POP || mode_reg == MODE_REMOVE) begin
                ctl.cmd = CMD_REMOVE;
            end
        end
    end

    // the row of cells, head at index 0
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic  left_ge;
        slot_t left_slot;
        slot_t right_slot;

        if (k == 0) begin : g_head
            assign left_ge   = 1'b1;
            assign left_slot = '0;
        end else begin : g_body
            assign left_ge   = ge_vec[k-1];
            assign left_slot = slots[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign right_slot = '0;
        end else begin : g_inner
            assign right_slot = slots[k+1];
        end

        spq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .left_ge    (left_ge),
            .left_slot  (left_slot),
            .right_slot (right_slot),
            .seen       (seen_vec[k]),
            .slot       (slots[k]),
            .ge         (ge_vec[k]),
            .match      (match_vec[k])
        );

        assign valid_vec[k] = slots[k].valid;
    end

    spq_first #(
        .CAPACITY (CAPACITY)
    ) u_first (
        .match (match_vec),
        .seen  (seen_vec),
        .first (first_vec)
    );

    // pick out the first matching entry
    always_comb begin
        sel_id   = '0;
        sel_prio = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            sel_id   = sel_id | (slots[k].id & {ID_W{first_vec[k]}});
            sel_prio = sel_prio | (slots[k].prio & {PRIO_W{first_vec[k]}});
        end
    end

    always_comb begin
        res_status = STATUS_DONE;
        res_id     = '0;
        res_prio   = '0;
        case (mode_reg)
            MODE_INSERT: begin
                if (q_full) begin
                    res_status = STATUS_FULL;
                end
            end
            MODE_POP, MODE_REMOVE: begin
                if (q_empty) begin
                    res_status = STATUS_EMPTY;
                end else if (!q_found) begin
                    res_status = STATUS_NOTFOUND;
                end else begin
                    res_id   = sel_id;
                    res_prio = sel_prio;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec_fire) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_status_reg <= res_status;
            m_id_reg     <= res_id;
            m_prio_reg   <= res_prio;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {{(32 - ID_W - PRIO_W){1'b0}}, m_prio_reg, m_id_reg};

    // occupied slots always form a prefix of the row
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("queue has a gap");

    // an accepted beat is executed before the next one is taken
    a_accept_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == S_EXEC) && !s_axis_tready)
        else $error("request not held for execution");

    // executing always leaves a result waiting
    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> m_axis_tvalid)
        else $error("result lost");

    // a successful insert grows the queue by one entry
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && mode_reg == MODE_INSERT && !q_full) |=>
            $countones(valid_vec) == $past($countones(valid_vec)) + 1)
        else $error("insert did not add one entry");

    // a successful removal shrinks the queue by one entry
    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && ctl.cmd == CMD_REMOVE && q_found) |=>
            $countones(valid_vec) + 1 == $past($countones(valid_vec)))
        else $error("removal did not take one entry");

endmodule

// ----- sv/spq_cell.sv -----
// one queue slot: holds an entry, compares against the request, shifts with neighbors
module spq_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic              left_ge,
    input  spq_pkg::slot_t    left_slot,
    input  spq_pkg::slot_t    right_slot,
    input  logic              seen,
    output spq_pkg::slot_t    slot,
    output logic              ge,
    output logic              match
);
    import spq_pkg::*;

    slot_t slot_reg, slot_next;
    logic  ge_reg, ge_next;
    logic  match_reg, match_next;

    always_comb begin
        slot_next  = slot_reg;
        ge_next    = ge_reg;
        match_next = match_reg;
        case (ctl.cmd)
            CMD_CAPTURE: begin
                ge_next    = slot_reg.valid && (slot_reg.prio >= ctl.prio);
                match_next = slot_reg.valid && (ctl.pop || (slot_reg.id == ctl.id));
            end
            CMD_INSERT: begin
                // entries of equal or higher priority stay, the rest move down
                if (!ge_reg) begin
                    if (left_ge) begin
                        slot_next.valid = 1'b1;
                        slot_next.id    = ctl.id;
                        slot_next.prio  = ctl.prio;
                    end else begin
                        slot_next = left_slot;
                    end
                end
            end
            CMD_REMOVE: begin
                // from the first match on, everything moves up one slot
                if (seen) begin
                    slot_next = right_slot;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        slot_reg.id   <= slot_next.id;
        slot_reg.prio <= slot_next.prio;
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
            ge_reg         <= 1'b0;
            match_reg      <= 1'b0;
        end else begin
            slot_reg.valid <= slot_next.valid;
            ge_reg         <= ge_next;
            match_reg      <= match_next;
        end
    end

    assign slot  = slot_reg;
    assign ge    = ge_reg;
    assign match = match_reg;

endmodule

// ----- sv/spq_first.sv -----
// log-depth prefix or over the match flags and one-hot first match
module spq_first #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic [CAPACITY-1:0] match,
    output logic [CAPACITY-1:0] seen,
    output logic [CAPACITY-1:0] first
);
    import spq_pkg::*;

    localparam int LEVELS = $clog2(CAPACITY);

    logic [CAPACITY-1:0] lvl [0:LEVELS];

    assign lvl[0] = match;

    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        assign lvl[l+1] = lvl[l] | (lvl[l] << (1 << l));
    end

    assign seen  = lvl[LEVELS];
    assign first = match & ~(seen << 1);

endmodule
